/* design/ast_pkg.sv */
// ----------------------------------------------------------------------------
// ast_pkg
// Shared types and codes of the aging session table.
// ----------------------------------------------------------------------------
`default_nettype none

package ast_pkg;

  localparam int NOW_W   = 48;
  localparam int INST_W  = 64;
  localparam int PORT_W  = 16;
  localparam int PROTO_W = 16;
  localparam int PART_W  = 8;
  localparam int ADDR_W  = 32;
  localparam int EXP_W   = 32;
  localparam int STAT_W  = 3;
  localparam int SLOT_W  = 4;
  localparam int CNT_W   = 5;

  localparam logic OP_ANNOUNCE = 1'b0;
  localparam logic OP_TICK     = 1'b1;

  localparam logic [STAT_W-1:0] ST_INSERTED      = 3'd0;
  localparam logic [STAT_W-1:0] ST_REFRESHED     = 3'd1;
  localparam logic [STAT_W-1:0] ST_REMOVED       = 3'd2;
  localparam logic [STAT_W-1:0] ST_CLOSE_UNKNOWN = 3'd3;
  localparam logic [STAT_W-1:0] ST_DROPPED_FULL  = 3'd4;
  localparam logic [STAT_W-1:0] ST_MALFORMED     = 3'd5;
  localparam logic [STAT_W-1:0] ST_TICK_DONE     = 3'd6;

  localparam logic [EXP_W-1:0] EXPIRY_RESET = 32'd5000;

  typedef struct packed {
    logic [INST_W-1:0]  instance_id;
    logic [NOW_W-1:0]   last_seen;
    logic [ADDR_W-1:0]  addr;
    logic [PORT_W-1:0]  port;
    logic [PROTO_W-1:0] protocol;
    logic [PART_W-1:0]  participants;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // controller -> datapath
  typedef struct packed {
    logic start;
    logic scan;
    logic decide;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

/* design/ast_in_if.sv */
// ----------------------------------------------------------------------------
// ast_in_if
// Input channel: one announcement or tick word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface ast_in_if;
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic [ast_pkg::NOW_W-1:0]    now_ms;
  logic [ast_pkg::INST_W-1:0]   instance_req;
  logic                         closing;
  logic [ast_pkg::PORT_W-1:0]   port;
  logic [ast_pkg::PROTO_W-1:0]  protocol;
  logic [ast_pkg::PART_W-1:0]   participants;
  logic [ast_pkg::ADDR_W-1:0]   source_addr;

  modport source (
    output valid, op, now_ms, instance_req, closing, port, protocol,
           participants, source_addr,
    input  ready
  );
  modport sink (
    input  valid, op, now_ms, instance_req, closing, port, protocol,
           participants, source_addr,
    output ready
  );
endinterface

`default_nettype wire

/* design/ast_out_if.sv */
// ----------------------------------------------------------------------------
// ast_out_if
// Result channel: one result word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface ast_out_if;
  logic                        valid;
  logic                        ready;
  logic [ast_pkg::STAT_W-1:0]  status;
  logic [ast_pkg::SLOT_W-1:0]  slot;
  logic [ast_pkg::CNT_W-1:0]   expired_count;
  logic [ast_pkg::CNT_W-1:0]   occupancy;

  modport source (
    output valid, status, slot, expired_count, occupancy,
    input  ready
  );
  modport sink (
    input  valid, status, slot, expired_count, occupancy,
    output ready
  );
endinterface

`default_nettype wire

/* design/ast_ram.sv */
// ----------------------------------------------------------------------------
// ast_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ast_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                               clk,
  input  wire logic                               we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                   wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                   rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* design/ast_dp.sv */
// ----------------------------------------------------------------------------
// ast_dp
// Datapath: item register, slot scan with match/free/expiry checks, valid
// bits, occupancy count, entry RAM and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ast_dp #(
  parameter int MAX_SESSIONS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire ast_pkg::cmd_t                 cmd,
  output ast_pkg::stat_t                     stat,
  input  wire logic                          cfg_wr_en,
  input  wire logic [ast_pkg::EXP_W-1:0]     cfg_wr_data,
  input  wire logic                          in_op,
  input  wire logic [ast_pkg::NOW_W-1:0]     in_now_ms,
  input  wire logic [ast_pkg::INST_W-1:0]    in_instance_req,
  input  wire logic                          in_closing,
  input  wire logic [ast_pkg::PORT_W-1:0]    in_port,
  input  wire logic [ast_pkg::PROTO_W-1:0]   in_protocol,
  input  wire logic [ast_pkg::PART_W-1:0]    in_participants,
  input  wire logic [ast_pkg::ADDR_W-1:0]    in_source_addr,
  ast_out_if.source                          out_ch
);

  localparam int IW = (MAX_SESSIONS > 1) ? $clog2(MAX_SESSIONS) : 1;
  localparam int CW = $clog2(MAX_SESSIONS + 1);
  localparam logic [CW-1:0] LAST = CW'(MAX_SESSIONS);

  logic [ast_pkg::EXP_W-1:0]   expiry_r;
  logic                        op_r;
  logic [ast_pkg::NOW_W-1:0]   now_r;
  logic [ast_pkg::INST_W-1:0]  inst_r;
  logic                        closing_r;
  logic [ast_pkg::PORT_W-1:0]  port_r;
  logic [ast_pkg::PROTO_W-1:0] proto_r;
  logic [ast_pkg::PART_W-1:0]  parts_r;
  logic [ast_pkg::ADDR_W-1:0]  addr_r;

  logic [CW-1:0]           idx_r;
  logic                    chk_v_r;
  logic [IW-1:0]           chk_idx_r;
  logic                    hit_f_r;
  logic [IW-1:0]           hit_idx_r;
  logic                    free_f_r;
  logic [IW-1:0]           free_idx_r;
  logic [CW-1:0]           exp_cnt_r;
  logic [CW-1:0]           occ_r;
  logic [MAX_SESSIONS-1:0] valid_r;

  logic                         out_valid_r;
  logic [ast_pkg::STAT_W-1:0]   out_status_r;
  logic [ast_pkg::SLOT_W-1:0]   out_slot_r;
  logic [ast_pkg::CNT_W-1:0]    out_exp_r;
  logic [ast_pkg::CNT_W-1:0]    out_occ_r;

  ast_pkg::entry_t rd_entry;
  ast_pkg::entry_t wr_entry;
  logic [ast_pkg::ENTRY_W-1:0] rd_bits;

  logic                      slot_v;
  logic [ast_pkg::NOW_W:0]   age;
  logic                      expire;

  logic [ast_pkg::STAT_W-1:0] res_status;
  logic [IW-1:0]              res_slot;
  logic                       wr_en;
  logic                       set_v;
  logic                       clr_v;
  logic [CW-1:0]              occ_nxt;

  assign rd_entry = ast_pkg::entry_t'(rd_bits);

  assign wr_entry.instance_id  = inst_r;
  assign wr_entry.last_seen    = now_r;
  assign wr_entry.addr         = addr_r;
  assign wr_entry.port         = port_r;
  assign wr_entry.protocol     = proto_r;
  assign wr_entry.participants = parts_r;

  ast_ram #(
    .WIDTH (ast_pkg::ENTRY_W),
    .DEPTH (MAX_SESSIONS)
  ) u_entry_ram (
    .clk   (clk),
    .we    (cmd.decide && wr_en),
    .waddr (res_slot),
    .wdata (wr_entry),
    .raddr (idx_r[IW-1:0]),
    .rdata (rd_bits)
  );

  // slot check stage, in the cycle after the RAM address is applied
  assign slot_v = valid_r[chk_idx_r];
  // borrow bit set means the entry was seen after now
  assign age    = {1'b0, now_r} - {1'b0, rd_entry.last_seen};
  assign expire = chk_v_r && (op_r == ast_pkg::OP_TICK) && slot_v && !age[ast_pkg::NOW_W] &&
                  (age[ast_pkg::NOW_W-1:0] > {16'd0, expiry_r});

  assign stat.scan_done = (idx_r == LAST) && !chk_v_r;
  assign stat.out_free  = !out_valid_r || out_ch.ready;

  always_comb begin
    res_status = ast_pkg::ST_TICK_DONE;
    res_slot   = hit_idx_r;
    wr_en      = 1'b0;
    set_v      = 1'b0;
    clr_v      = 1'b0;
    occ_nxt    = occ_r;
    if (op_r == ast_pkg::OP_TICK) begin
      res_slot = '0;
    end else if (port_r == '0) begin
      res_status = ast_pkg::ST_MALFORMED;
      res_slot   = '0;
    end else if (closing_r) begin
      if (hit_f_r) begin
        res_status = ast_pkg::ST_REMOVED;
        clr_v      = 1'b1;
        occ_nxt    = occ_r - 1'b1;
      end else begin
        res_status = ast_pkg::ST_CLOSE_UNKNOWN;
        res_slot   = '0;
      end
    end else if (hit_f_r) begin
      res_status = ast_pkg::ST_REFRESHED;
      wr_en      = 1'b1;
    end else if (free_f_r) begin
      res_status = ast_pkg::ST_INSERTED;
      res_slot   = free_idx_r;
      wr_en      = 1'b1;
      set_v      = 1'b1;
      occ_nxt    = occ_r + 1'b1;
    end else begin
      res_status = ast_pkg::ST_DROPPED_FULL;
      res_slot   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expiry_r <= ast_pkg::EXPIRY_RESET;
    end else if (cfg_wr_en) begin
      expiry_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r      <= in_op;
      now_r     <= in_now_ms;
      inst_r    <= in_instance_req;
      closing_r <= in_closing;
      port_r    <= in_port;
      proto_r   <= in_protocol;
      parts_r   <= in_participants;
      addr_r    <= in_source_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      chk_v_r   <= 1'b0;
      chk_idx_r <= '0;
      hit_f_r   <= 1'b0;
      free_f_r  <= 1'b0;
      exp_cnt_r <= '0;
    end else if (cmd.start) begin
      idx_r     <= '0;
      chk_v_r   <= 1'b0;
      hit_f_r   <= 1'b0;
      free_f_r  <= 1'b0;
      exp_cnt_r <= '0;
    end else begin
      chk_v_r <= cmd.scan && (idx_r != LAST);
      if (cmd.scan && (idx_r != LAST)) begin
        idx_r     <= idx_r + 1'b1;
        chk_idx_r <= idx_r[IW-1:0];
      end
      if (expire) begin
        exp_cnt_r <= exp_cnt_r + 1'b1;
      end
      if (chk_v_r && (op_r == ast_pkg::OP_ANNOUNCE)) begin
        if (slot_v && !hit_f_r && (rd_entry.instance_id == inst_r)) begin
          hit_f_r   <= 1'b1;
          hit_idx_r <= chk_idx_r;
        end
        if (!slot_v && !free_f_r) begin
          free_f_r   <= 1'b1;
          free_idx_r <= chk_idx_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r   <= '0;
    end else begin
      if (expire) begin
        valid_r[chk_idx_r] <= 1'b0;
        occ_r              <= occ_r - 1'b1;
      end else if (cmd.decide) begin
        occ_r <= occ_nxt;
        if (set_v) begin
          valid_r[res_slot] <= 1'b1;
        end
        if (clr_v) begin
          valid_r[res_slot] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.decide) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      out_status_r <= res_status;
      out_slot_r   <= ast_pkg::SLOT_W'(res_slot);
      out_exp_r    <= ast_pkg::CNT_W'(exp_cnt_r);
      out_occ_r    <= ast_pkg::CNT_W'(occ_nxt);
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.slot          = out_slot_r;
  assign out_ch.expired_count = out_exp_r;
  assign out_ch.occupancy     = out_occ_r;

endmodule

`default_nettype wire

/* design/ast_ctrl.sv */
// ----------------------------------------------------------------------------
// ast_ctrl
// Controller: accept a word, run the slot scan, then commit and emit the
// result once the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module ast_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire ast_pkg::stat_t  stat,
  output ast_pkg::cmd_t        cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd.start  = 1'b0;
    cmd.scan   = 1'b0;
    cmd.decide = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
        if (in_valid) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = stat.out_free;
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

/* design/aging_session_table_top.sv */
// ----------------------------------------------------------------------------
// aging_session_table_top
// Session table keyed by instance id with insert/refresh/remove and aging.
//
//   channel  dir  handshake      word
//   in_ch    in   valid/ready    op, now_ms, instance_req, closing, port,
//                                protocol, participants, source_addr
//   out_ch   out  valid/ready    status, slot, expired_count, occupancy
//   cfg_*    in   write enable   expiry_ms
//
// One word at a time: a new word is accepted only after the scan and the
// commit of the last one; the scan does one entry RAM read per cycle.
// Reset empties the table at once (valid bits) and loads expiry 5000.
// A result waiting in the output register does not block the next accept;
// the commit cycle waits until that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module aging_session_table_top #(
  parameter int MAX_SESSIONS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_wr_en,
  input  wire logic [ast_pkg::EXP_W-1:0]  cfg_wr_data,
  ast_in_if.sink                          in_ch,
  ast_out_if.source                       out_ch
);

  ast_pkg::cmd_t  cmd;
  ast_pkg::stat_t stat;
  logic           in_ready;

  assign in_ch.ready = in_ready;

  ast_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ast_dp #(
    .MAX_SESSIONS (MAX_SESSIONS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_op           (in_ch.op),
    .in_now_ms       (in_ch.now_ms),
    .in_instance_req (in_ch.instance_req),
    .in_closing      (in_ch.closing),
    .in_port         (in_ch.port),
    .in_protocol     (in_ch.protocol),
    .in_participants (in_ch.participants),
    .in_source_addr  (in_ch.source_addr),
    .out_ch          (out_ch)
  );

endmodule

`default_nettype wire

/* test/aging_session_table_checker.sv */
// ----------------------------------------------------------------------------
// aging_session_table_checker
// Watches the word and result channels of the session table, keeps its own
// copy of the table and the expiry, and compares every result word with the
// one predicted for the oldest outstanding word.
// ----------------------------------------------------------------------------
`default_nettype none

module aging_session_table_checker #(
  parameter int SLOTS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_wr_en,
  input  wire logic [ast_pkg::EXP_W-1:0]  cfg_wr_data,
  ast_in_if                               in_mon,
  ast_out_if                              out_mon,
  output int                              errors,
  output int                              outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import ast_pkg::*;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  expired_count;
    logic [CNT_W-1:0]  occupancy;
  } result_t;

  logic [EXP_W-1:0] expiry_q;
  logic             live [SLOTS];
  entry_t           sessions [SLOTS];
  result_t          results_due [$];

  initial errors = 0;

  // Applies one word to the model table and returns the result it yields.
  function automatic result_t table_update(
    input logic               op,
    input logic [NOW_W-1:0]   now,
    input logic [INST_W-1:0]  id,
    input logic               bye,
    input logic [PORT_W-1:0]  port_no,
    input logic [PROTO_W-1:0] proto,
    input logic [PART_W-1:0]  parts,
    input logic [ADDR_W-1:0]  addr
  );
    result_t r;
    int      hit;
    int      free_at;
    int      pick;
    int      n;
    r = '0;
    if (op == OP_TICK) begin
      for (int i = 0; i < SLOTS; i++) begin
        // a last-seen time at or after now never ages out
        if (live[i] && now > sessions[i].last_seen &&
            (now - sessions[i].last_seen) > {{(NOW_W-EXP_W){1'b0}}, expiry_q}) begin
          live[i] = 1'b0;
          r.expired_count = r.expired_count + 1'b1;
        end
      end
      r.status = ST_TICK_DONE;
    end else if (port_no == '0) begin
      r.status = ST_MALFORMED;
    end else begin
      hit = -1;
      free_at = -1;
      for (int i = 0; i < SLOTS; i++) begin
        if (live[i]) begin
          if (hit < 0 && sessions[i].instance_id == id) hit = i;
        end else if (free_at < 0) begin
          free_at = i;
        end
      end
      if (bye) begin
        if (hit >= 0) begin
          live[hit] = 1'b0;
          r.slot = SLOT_W'(hit);
          r.status = ST_REMOVED;
        end else begin
          r.status = ST_CLOSE_UNKNOWN;
        end
      end else begin
        pick = -1;
        if (hit >= 0) begin
          pick = hit;
          r.status = ST_REFRESHED;
        end else if (free_at >= 0) begin
          pick = free_at;
          r.status = ST_INSERTED;
        end else begin
          r.status = ST_DROPPED_FULL;
        end
        if (pick >= 0) begin
          live[pick] = 1'b1;
          sessions[pick].instance_id = id;
          sessions[pick].last_seen = now;
          sessions[pick].addr = addr;
          sessions[pick].port = port_no;
          sessions[pick].protocol = proto;
          sessions[pick].participants = parts;
          r.slot = SLOT_W'(pick);
        end
      end
    end
    n = 0;
    for (int i = 0; i < SLOTS; i++) if (live[i]) n++;
    r.occupancy = CNT_W'(n);
    return r;
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    result_t pred;
    if (!rst_n) begin
      expiry_q = EXPIRY_RESET;
      for (int i = 0; i < SLOTS; i++) live[i] = 1'b0;
      results_due.delete();
    end else begin
      // results first: a word accepted at this edge cannot have its result yet
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.status, out_mon.slot, out_mon.expired_count, out_mon.occupancy};
        if (results_due.size() == 0) begin
          if (errors < 10)
            $display("checker: unexpected result word status %0d slot %0d expired %0d occ %0d",
                     got.status, got.slot, got.expired_count, got.occupancy);
          errors++;
        end else begin
          want = results_due.pop_front();
          if (got.status !== want.status || got.slot !== want.slot ||
              got.expired_count !== want.expired_count ||
              got.occupancy !== want.occupancy) begin
            if (errors < 10) begin
              $write("checker: mismatch at %0t: status %0d/%0d slot %0d/%0d ", $realtime,
                     want.status, got.status, want.slot, got.slot);
              $display("expired %0d/%0d occ %0d/%0d (expected/actual)",
                       want.expired_count, got.expired_count,
                       want.occupancy, got.occupancy);
            end
            errors++;
          end
        end
      end
      if (cfg_wr_en) expiry_q = cfg_wr_data;
      if (in_mon.valid && in_mon.ready) begin
        pred = table_update(in_mon.op, in_mon.now_ms, in_mon.instance_req,
                            in_mon.closing, in_mon.port, in_mon.protocol,
                            in_mon.participants, in_mon.source_addr);
        results_due = {results_due, pred};
      end
    end
    outstanding <= results_due.size();
  end

endmodule

`default_nettype wire

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives announcement and tick words into the session table with random
// gaps and result back-pressure, steps the expiry through several values,
// and reports the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ast_pkg::*;

  localparam int SLOTS       = 16;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic               op;
    logic [NOW_W-1:0]   now_ms;
    logic [INST_W-1:0]  instance_req;
    logic               closing;
    logic [PORT_W-1:0]  port;
    logic [PROTO_W-1:0] protocol;
    logic [PART_W-1:0]  participants;
    logic [ADDR_W-1:0]  source_addr;
  } word_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [EXP_W-1:0] cfg_wr_data;
  int               errors;
  int               outstanding;
  int               quiet_cycles;

  bit                idle_on;
  logic [NOW_W-1:0]  clock_ms;
  logic [INST_W-1:0] id_pool [32];
  int unsigned       pool_len;
  int unsigned       time_step;

  ast_in_if  in_ch ();
  ast_out_if out_ch ();

  aging_session_table_top #(.MAX_SESSIONS(SLOTS)) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  aging_session_table_checker #(.SLOTS(SLOTS)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // result side back-pressure
  always begin
    @(posedge clk);
    if (idle_on && rst_n && $urandom_range(0, 4) == 0) begin
      out_ch.ready <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    out_ch.ready <= 1'b1;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  function automatic word_t announce(input logic [NOW_W-1:0] at, input logic [INST_W-1:0] id,
                                     input logic bye, input logic [PORT_W-1:0] port_no);
    word_t w;
    w.op           = OP_ANNOUNCE;
    w.now_ms       = at;
    w.instance_req = id;
    w.closing      = bye;
    w.port         = port_no;
    w.protocol     = PROTO_W'($urandom);
    w.participants = PART_W'($urandom);
    w.source_addr  = $urandom;
    return w;
  endfunction

  // announcement fields of a tick are don't-care, so fill them with noise
  function automatic word_t tick_at(input logic [NOW_W-1:0] at);
    word_t w;
    w = announce(at, {$urandom, $urandom}, 1'($urandom), PORT_W'($urandom));
    w.op = OP_TICK;
    return w;
  endfunction

  function automatic word_t next_word();
    int unsigned       t;
    int unsigned       k;
    logic [INST_W-1:0] id;
    word_t             w;
    t = $urandom_range(0, 99);
    if (t < 3)
      clock_ms = clock_ms - NOW_W'($urandom_range(1, 2000));      // clock steps back
    else if (t < 6)
      clock_ms = NOW_W'({$urandom, $urandom});
    else if (t < 10)
      clock_ms = clock_ms + NOW_W'({$urandom_range(0, 3), $urandom});
    else
      clock_ms = clock_ms + NOW_W'($urandom_range(0, time_step));
    id = id_pool[$urandom_range(0, pool_len - 1)];
    k = $urandom_range(0, 99);
    if (k < 50)
      w = announce(clock_ms, id, 1'b0, PORT_W'($urandom_range(1, 65535)));
    else if (k < 62)
      w = announce(clock_ms, id, 1'b1, PORT_W'($urandom_range(1, 65535)));
    else if (k < 66)
      w = announce(clock_ms, {$urandom, $urandom}, 1'b1, PORT_W'($urandom_range(1, 65535)));
    else if (k < 71)
      w = announce(clock_ms, id, 1'($urandom), '0);
    else if (k < 86)
      w = tick_at(clock_ms);
    else begin
      w = announce(NOW_W'({$urandom, $urandom}), {$urandom, $urandom}, 1'($urandom),
                   PORT_W'($urandom));
      w.op = 1'($urandom);
    end
    return w;
  endfunction

  task automatic send_word(input word_t w);
    int gap;
    in_ch.valid        <= 1'b1;
    in_ch.op           <= w.op;
    in_ch.now_ms       <= w.now_ms;
    in_ch.instance_req <= w.instance_req;
    in_ch.closing      <= w.closing;
    in_ch.port         <= w.port;
    in_ch.protocol     <= w.protocol;
    in_ch.participants <= w.participants;
    in_ch.source_addr  <= w.source_addr;
    do @(posedge clk); while (!in_ch.ready);
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 16);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (25) @(posedge clk);
  endtask

  task automatic set_expiry(input logic [EXP_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic run_phase(input bit write_cfg, input logic [EXP_W-1:0] expiry,
                           input int unsigned step, input int unsigned pool,
                           input int count, input bit may_idle);
    drain();
    if (write_cfg) set_expiry(expiry);
    time_step = step;
    pool_len  = pool;
    for (int i = 0; i < pool; i++) id_pool[i] = {$urandom, $urandom};
    if ($urandom_range(0, 1) == 1) id_pool[0] = '0;
    if ($urandom_range(0, 1) == 1) id_pool[pool - 1] = '1;
    for (int n = 0; n < count; n++) begin
      if (n % 64 == 0) idle_on = may_idle && ($urandom_range(0, 3) != 0);
      send_word(next_word());
    end
  endtask

  initial begin
    word_t            w;
    logic [EXP_W-1:0] e;
    rst_n              <= 1'b0;
    cfg_wr_en          <= 1'b0;
    cfg_wr_data        <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.op           <= OP_ANNOUNCE;
    in_ch.now_ms       <= '0;
    in_ch.instance_req <= '0;
    in_ch.closing      <= 1'b0;
    in_ch.port         <= '0;
    in_ch.protocol     <= '0;
    in_ch.participants <= '0;
    in_ch.source_addr  <= '0;
    out_ch.ready       <= 1'b0;
    idle_on  = 1'b1;
    clock_ms = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed words, reset expiry of 5000
    send_word(tick_at('0));                           // empty table
    send_word(announce(NOW_W'(100), '0, 1'b0, PORT_W'(1)));
    w = announce(NOW_W'(100), '1, 1'b0, '1);
    w.protocol = '1;
    w.participants = '1;
    w.source_addr = '1;
    send_word(w);
    send_word(announce(NOW_W'(100), '0, 1'b0, PORT_W'(80)));  // refresh
    send_word(announce(NOW_W'(100), '0, 1'b1, '0));           // goodbye with zero port
    send_word(announce(NOW_W'(100), '1, 1'b0, '0));
    send_word(announce(NOW_W'(100), INST_W'(5), 1'b1, PORT_W'(7)));
    send_word(announce(NOW_W'(100), '1, 1'b1, PORT_W'(9)));   // removes slot 1
    for (int i = 1; i < SLOTS; i++)
      send_word(announce(NOW_W'(200 + i), {$urandom, $urandom}, 1'b0,
                         PORT_W'($urandom_range(1, 65535))));
    send_word(announce(NOW_W'(300), {$urandom, $urandom}, 1'b0, PORT_W'(443)));  // full
    send_word(tick_at(NOW_W'(50)));                   // time behind every entry
    send_word(tick_at(NOW_W'(5100)));                 // age exactly at the limit
    send_word(tick_at('1));                           // everything ages out

    clock_ms = NOW_W'(1000);
    run_phase(1'b0, EXPIRY_RESET, 600, 20, 150, 1'b1);
    run_phase(1'b1, '0, 2, 12, 150, 1'b1);
    run_phase(1'b1, '1, 5000, 24, 150, 1'b1);
    run_phase(1'b1, EXP_W'(1), 3, 20, 150, 1'b1);
    e = EXP_W'($urandom_range(10, 2000));
    run_phase(1'b1, e, e / 3 + 1, $urandom_range(8, 32), 200, 1'b1);
    run_phase(1'b1, EXP_W'($urandom), 1000, 32, 150, 1'b1);
    run_phase(1'b1, EXPIRY_RESET, 600, 20, 275, 1'b0);
    drain();

    if (errors == 0 && outstanding == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
design/ast_pkg.sv
design/ast_in_if.sv
design/ast_out_if.sv
design/ast_ram.sv
design/ast_dp.sv
design/ast_ctrl.sv
design/aging_session_table_top.sv
test/aging_session_table_checker.sv
test/testbench.sv
